### rtl/core/fat12_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_pkg
// Shared types and codes for the FAT12 cluster table engine.
// ----------------------------------------------------------------------------
package fat12_pkg;

    typedef enum logic [3:0] {
        K_LOAD_BYTE  = 4'd0,
        K_READ_BYTE  = 4'd1,
        K_READ_ENTRY = 4'd2,
        K_WRITE_ENTRY = 4'd3,
        K_ALLOCATE   = 4'd4,
        K_FIND_LAST  = 4'd5,
        K_APPEND     = 4'd6,
        K_FREE_CHAIN = 4'd7,
        K_CHAIN_LEN  = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LOOP  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RBYTE,
        S_RENT,
        S_WALK,
        S_SCAN,
        S_APPEND,
        S_FREE,
        S_FREE_RD,
        S_DONE
    } t_state;

    localparam logic [11:0] ENTRY_MASK    = 12'hFFF;
    localparam logic [11:0] CHAIN_END_MIN = 12'hFF8;

    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_FIRST   = 1'b1;

    typedef struct packed {
        logic        re;
        logic        we;
        logic        byte_mode;
        logic [11:0] ent;
        logic [12:0] addr;
        logic [11:0] wval;
        logic [7:0]  wbyte;
    } t_mem_req;

    typedef struct packed {
        logic [12:0] chain_clusters;
        logic [11:0] result_cluster;
        logic [7:0]  byte_value;
        logic [11:0] entry_value;
        t_status     status;
    } t_result;

endpackage

### rtl/core/fat12_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_mem
// Packed table in two byte banks (even and odd byte addresses), so one
// 12-bit entry reads or writes in one access with nibble write enables.
// ----------------------------------------------------------------------------
module fat12_mem import fat12_pkg::*; #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [11:0] o_entry,
    output logic [7:0]  o_byte
);
    localparam int TableSize = (MAX_ENTRIES * 3 + 1) / 2;
    localparam int Depth     = (TableSize + 1) / 2;
    localparam int AW        = $clog2(Depth);

    logic [7:0] bank0 [Depth];
    logic [7:0] bank1 [Depth];

    logic [12:0] pos;
    logic        sel;
    logic [11:0] a_base;
    logic [AW-1:0] a0, a1;
    logic [1:0]  lo_en, hi_en, en0, en1;
    logic [7:0]  lo_d, hi_d, d0, d1;
    logic [7:0]  q0, q1, lo, hi;
    logic        r_sel, r_odd;

    always_comb begin
        pos = i_req.byte_mode ? i_req.addr
                              : ({1'b0, i_req.ent} + {2'b00, i_req.ent[11:1]});
        sel    = pos[0];
        a_base = pos[12:1];
        a1     = AW'(a_base);
        a0     = sel ? AW'(a_base + 12'd1) : AW'(a_base);
        if (i_req.byte_mode) begin
            lo_en = 2'b11; lo_d = i_req.wbyte;
            hi_en = 2'b00; hi_d = 8'h00;
        end else if (i_req.ent[0]) begin
            lo_en = 2'b10; lo_d = {i_req.wval[3:0], 4'h0};
            hi_en = 2'b11; hi_d = i_req.wval[11:4];
        end else begin
            lo_en = 2'b11; lo_d = i_req.wval[7:0];
            hi_en = 2'b01; hi_d = {4'h0, i_req.wval[11:8]};
        end
        en0 = i_req.we ? (sel ? hi_en : lo_en) : 2'b00;
        en1 = i_req.we ? (sel ? lo_en : hi_en) : 2'b00;
        d0  = sel ? hi_d : lo_d;
        d1  = sel ? lo_d : hi_d;
    end

    always_ff @(posedge i_clk) begin
        if (en0[0]) bank0[a0][3:0] <= d0[3:0];
        if (en0[1]) bank0[a0][7:4] <= d0[7:4];
        if (en1[0]) bank1[a1][3:0] <= d1[3:0];
        if (en1[1]) bank1[a1][7:4] <= d1[7:4];
        if (i_req.re) begin
            q0    <= bank0[a0];
            q1    <= bank1[a1];
            r_sel <= sel;
            r_odd <= i_req.ent[0] & ~i_req.byte_mode;
        end
    end

    always_comb begin
        lo      = r_sel ? q1 : q0;
        hi      = r_sel ? q0 : q1;
        o_byte  = lo;
        o_entry = r_odd ? {hi, lo[7:4]} : {hi[3:0], lo};
    end

endmodule

### rtl/core/fat12_eng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_eng
// Sequencer: dispatches one command, walks chains and scans for free
// entries through the table memory, and holds the result until taken.
// ----------------------------------------------------------------------------
module fat12_eng import fat12_pkg::*; #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_kind,
    input  logic [11:0] i_cluster,
    input  logic [11:0] i_entry_data,
    input  logic [12:0] i_byte_address,
    input  logic [7:0]  i_byte_data,
    input  logic [12:0] i_entries_in_use,
    input  logic [11:0] i_first_search_entry,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);
    localparam logic [13:0] TableSize = 14'((MAX_ENTRIES * 3 + 1) / 2);
    localparam logic [12:0] MaxEnt    = 13'(MAX_ENTRIES);

    t_state      r_state, n_state;
    logic [3:0]  r_kind, n_kind;
    logic [11:0] r_cl, n_cl;
    logic [11:0] r_cur, n_cur;
    logic [11:0] r_last, n_last;
    logic [12:0] r_n, n_n;
    logic [12:0] r_i, n_i;
    t_result     r_res, n_res;
    t_mem_req    req;
    logic [11:0] rd_entry;
    logic [7:0]  rd_byte;
    logic [12:0] lim, i_inc;
    logic [12:0] first_ext;
    logic        is_free;

    fat12_mem #(.MAX_ENTRIES(MAX_ENTRIES)) u_mem (
        .i_clk  (i_clk),
        .i_req  (req),
        .o_entry(rd_entry),
        .o_byte (rd_byte)
    );

    assign lim       = (i_entries_in_use > MaxEnt) ? MaxEnt : i_entries_in_use;
    assign first_ext = {1'b0, i_first_search_entry};
    assign i_inc     = r_i + 13'd1;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kind <= n_kind;
        r_cl   <= n_cl;
        r_cur  <= n_cur;
        r_last <= n_last;
        r_n    <= n_n;
        r_i    <= n_i;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_cl    = r_cl;
        n_cur   = r_cur;
        n_last  = r_last;
        n_n     = r_n;
        n_i     = r_i;
        n_res   = r_res;
        req     = '0;
        o_ready = 1'b0;
        o_res_valid = 1'b0;
        is_free = (rd_entry == 12'h000) &&
                  !((r_kind == K_APPEND) && (r_i[11:0] == r_last));

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_cl    = i_cluster;
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_kind)
                        K_LOAD_BYTE: begin
                            if ({1'b0, i_byte_address} < TableSize) begin
                                req.we        = 1'b1;
                                req.byte_mode = 1'b1;
                                req.addr      = i_byte_address;
                                req.wbyte     = i_byte_data;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        K_READ_BYTE: begin
                            if ({1'b0, i_byte_address} < TableSize) begin
                                req.re        = 1'b1;
                                req.byte_mode = 1'b1;
                                req.addr      = i_byte_address;
                                n_state       = S_RBYTE;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        K_READ_ENTRY: begin
                            if ({1'b0, i_cluster} < lim) begin
                                req.re  = 1'b1;
                                req.ent = i_cluster;
                                n_state = S_RENT;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        K_WRITE_ENTRY: begin
                            if ({1'b0, i_cluster} < lim) begin
                                req.we   = 1'b1;
                                req.ent  = i_cluster;
                                req.wval = i_entry_data;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        K_ALLOCATE: begin
                            n_i = first_ext;
                            if (first_ext < lim) begin
                                req.re  = 1'b1;
                                req.ent = i_first_search_entry;
                                n_state = S_SCAN;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        K_FIND_LAST, K_APPEND, K_FREE_CHAIN, K_CHAIN_LEN: begin
                            if ({1'b0, i_cluster} < lim) begin
                                n_cur   = i_cluster;
                                n_n     = 13'd1;
                                req.re  = 1'b1;
                                req.ent = i_cluster;
                                n_state = S_WALK;
                            end else begin
                                n_res.status = ST_RANGE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RBYTE: begin
                n_res.byte_value = rd_byte;
                n_state = S_DONE;
            end
            S_RENT: begin
                n_res.entry_value = rd_entry;
                n_state = S_DONE;
            end
            S_WALK: begin
                if (rd_entry == 12'h000 || rd_entry >= CHAIN_END_MIN) begin
                    n_state = S_DONE;
                    case (r_kind)
                        K_FIND_LAST: n_res.result_cluster = r_cur;
                        K_CHAIN_LEN: n_res.chain_clusters = r_n;
                        K_APPEND: begin
                            n_last = r_cur;
                            n_i    = first_ext;
                            if (first_ext < lim) begin
                                req.re  = 1'b1;
                                req.ent = i_first_search_entry;
                                n_state = S_SCAN;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        K_FREE_CHAIN: begin
                            n_res.chain_clusters = r_n;
                            n_i     = 13'd0;
                            n_cur   = r_cl;
                            req.re  = 1'b1;
                            req.ent = r_cl;
                            n_state = S_FREE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end else if ({1'b0, rd_entry} >= lim) begin
                    n_res.status = ST_RANGE;
                    n_state = S_DONE;
                end else if (r_n >= lim) begin
                    n_res.status = ST_LOOP;
                    n_state = S_DONE;
                end else begin
                    n_cur   = rd_entry;
                    n_n     = r_n + 13'd1;
                    req.re  = 1'b1;
                    req.ent = rd_entry;
                end
            end
            S_SCAN: begin
                if (is_free) begin
                    n_res.result_cluster = r_i[11:0];
                    req.we = 1'b1;
                    if (r_kind == K_APPEND) begin
                        req.ent  = r_last;
                        req.wval = r_i[11:0];
                        n_state  = S_APPEND;
                    end else begin
                        req.ent  = r_i[11:0];
                        req.wval = ENTRY_MASK;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_i = i_inc;
                    if (i_inc >= lim) begin
                        n_res.status = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        req.re  = 1'b1;
                        req.ent = i_inc[11:0];
                    end
                end
            end
            S_APPEND: begin
                req.we   = 1'b1;
                req.ent  = r_res.result_cluster;
                req.wval = ENTRY_MASK;
                n_state  = S_DONE;
            end
            S_FREE: begin
                req.we   = 1'b1;
                req.ent  = r_cur;
                req.wval = 12'h000;
                n_cur    = rd_entry;
                n_i      = i_inc;
                n_state  = (i_inc == r_n) ? S_DONE : S_FREE_RD;
            end
            S_FREE_RD: begin
                req.re  = 1'b1;
                req.ent = r_cur;
                n_state = S_FREE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/core/fat12_cluster_table_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_top
// FAT12 allocation table engine with stream command and result ports.
// ----------------------------------------------------------------------------
// One command is handled at a time; every command gives exactly one result.
// Load byte, write entry, an unknown kind or a command rejected up front go
// straight to the result; read byte and read entry first wait for the
// registered table read. Chain commands read one link at a time (the walk is
// bounded by the entry count), the free search reads one entry at a time,
// append adds a second entry write, and freeing a chain alternates writes and
// reads, one write per cluster released. All table access goes through the
// single table memory, a registered read/write port over two byte banks. The
// table contents are undefined after reset until loaded; no clearing pass is run.
module fat12_cluster_table_engine_top import fat12_pkg::*; #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] cluster, [23:12] entry_data, [36:24] byte_address,
    // [44:37] byte_data, [47:45] zero
    input  logic [47:0] i_s_tdata,
    // [3:0] kind
    input  logic [3:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [11:0] entry_value, [19:12] byte_value, [31:20] result_cluster,
    // [44:32] chain_clusters, [47:45] zero
    output logic [47:0] o_m_tdata,
    // [1:0] status
    output logic [1:0]  o_m_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);
    logic [12:0] r_entries_in_use;
    logic [11:0] r_first_search;
    logic        r_m_valid;
    t_result     r_m_res;
    logic        res_valid, res_ready;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= 13'd3072;
            r_first_search   <= 12'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRIES: r_entries_in_use <= i_cfg_data;
                CFG_FIRST:   r_first_search   <= i_cfg_data[11:0];
                default:     r_first_search   <= r_first_search;
            endcase
        end
    end

    fat12_eng #(.MAX_ENTRIES(MAX_ENTRIES)) u_eng (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_s_tvalid),
        .o_ready             (o_s_tready),
        .i_kind              (i_s_tuser),
        .i_cluster           (i_s_tdata[11:0]),
        .i_entry_data        (i_s_tdata[23:12]),
        .i_byte_address      (i_s_tdata[36:24]),
        .i_byte_data         (i_s_tdata[44:37]),
        .i_entries_in_use    (r_entries_in_use),
        .i_first_search_entry(r_first_search),
        .o_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .o_res               (res)
    );

    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_m_res.chain_clusters, r_m_res.result_cluster,
                         r_m_res.byte_value, r_m_res.entry_value};
    assign o_m_tuser  = r_m_res.status;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("engine accepted a command while busy");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |=> o_m_tvalid)
        else $error("finished result not presented");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !o_s_tready)
        else $error("ready raised while a result is pending");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT12 cluster table engine. The low part of the
// table is first filled with zeros, then a directed table of commands, a
// short saturated-count check and several phases of random commands run
// under different entry counts and search starts. A table-level predictor
// gives the expected result of each command, or a directed row carries its own,
// and each result transfer is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import fat12_pkg::*;

    localparam int TABLE_BYTES = 6144;
    localparam int TABLE_ENTRIES = 4096;
    localparam int CLEAR_BYTES = 768;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        logic [11:0] entry_value;
        logic [7:0]  byte_value;
        logic [11:0] result_cluster;
        logic [12:0] chain_clusters;
        t_status     status;
    } fat_res_t;

    typedef struct {
        logic [3:0]  kind;
        logic [11:0] cluster;
        logic [11:0] entry_data;
        logic [12:0] byte_address;
        logic [7:0]  byte_data;
        bit          typed;
        fat_res_t    res;
    } cmd_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic [3:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [12:0] i_cfg_data = '0;

    fat12_cluster_table_engine_top uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // table image and register copies
    logic [7:0]  fat_image [TABLE_BYTES];
    logic [12:0] cfg_entries = 13'd3072;
    logic [11:0] cfg_first = 12'd4;
    fat_res_t    pending_results [$];
    logic [11:0] chain_heads [$];
    int          mismatches = 0;
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;
    int          ready_hold = 0;

    function automatic int in_range_limit();
        return (cfg_entries > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_entries);
    endfunction

    function automatic logic [11:0] entry_get(int idx);
        int o;
        logic [15:0] w;
        o = (idx * 3) / 2;
        if (o + 1 >= TABLE_BYTES) return 12'd0;
        w = {fat_image[o + 1], fat_image[o]};
        return idx[0] ? w[15:4] : w[11:0];
    endfunction

    function automatic void entry_set(int idx, logic [11:0] v);
        int o;
        o = (idx * 3) / 2;
        if (o + 1 >= TABLE_BYTES) return;
        if (idx[0]) begin
            fat_image[o + 1] = v[11:4];
            fat_image[o] = {v[3:0], fat_image[o][3:0]};
        end else begin
            fat_image[o] = v[7:0];
            fat_image[o + 1] = {fat_image[o + 1][7:4], v[11:8]};
        end
    endfunction

    function automatic t_status chain_walk(int start, output int last, output int cnt);
        int lim;
        int cur;
        int n;
        logic [11:0] nxt;
        lim = in_range_limit();
        cur = start;
        n = 1;
        last = 0;
        cnt = 0;
        if (start >= lim) return ST_RANGE;
        forever begin
            nxt = entry_get(cur);
            if (nxt == 12'd0 || nxt >= CHAIN_END_MIN) begin
                last = cur;
                cnt = n;
                return ST_OK;
            end
            if (int'(nxt) >= lim) return ST_RANGE;
            if (n >= lim) return ST_LOOP;
            cur = nxt;
            n++;
        end
    endfunction

    function automatic bit free_search(int skip, bit use_skip, output int found);
        int lim;
        lim = in_range_limit();
        found = 0;
        for (int i = cfg_first; i < lim; i++) begin
            if (use_skip && i == skip) continue;
            if (entry_get(i) == 12'd0) begin
                found = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic fat_res_t table_apply(cmd_row_t c);
        fat_res_t r;
        int last;
        int cnt;
        int fr;
        int cur;
        logic [11:0] nxt;
        r = '{12'd0, 8'd0, 12'd0, 13'd0, ST_OK};
        case (c.kind)
            K_LOAD_BYTE: begin
                if (c.byte_address < TABLE_BYTES) fat_image[c.byte_address] = c.byte_data;
                else r.status = ST_RANGE;
            end
            K_READ_BYTE: begin
                if (c.byte_address < TABLE_BYTES) r.byte_value = fat_image[c.byte_address];
                else r.status = ST_RANGE;
            end
            K_READ_ENTRY: begin
                if (c.cluster < in_range_limit()) r.entry_value = entry_get(c.cluster);
                else r.status = ST_RANGE;
            end
            K_WRITE_ENTRY: begin
                if (c.cluster < in_range_limit()) entry_set(c.cluster, c.entry_data);
                else r.status = ST_RANGE;
            end
            K_ALLOCATE: begin
                if (free_search(0, 1'b0, fr)) begin
                    entry_set(fr, ENTRY_MASK);
                    r.result_cluster = 12'(fr);
                end else begin
                    r.status = ST_FULL;
                end
            end
            K_FIND_LAST: begin
                r.status = chain_walk(c.cluster, last, cnt);
                if (r.status == ST_OK) r.result_cluster = 12'(last);
            end
            K_APPEND: begin
                r.status = chain_walk(c.cluster, last, cnt);
                if (r.status == ST_OK) begin
                    if (free_search(last, 1'b1, fr)) begin
                        entry_set(last, 12'(fr));
                        entry_set(fr, ENTRY_MASK);
                        r.result_cluster = 12'(fr);
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            K_FREE_CHAIN: begin
                r.status = chain_walk(c.cluster, last, cnt);
                if (r.status == ST_OK) begin
                    cur = c.cluster;
                    for (int i = 0; i < cnt; i++) begin
                        nxt = entry_get(cur);
                        entry_set(cur, 12'd0);
                        cur = nxt;
                    end
                    r.chain_clusters = 13'(cnt);
                end
            end
            K_CHAIN_LEN: begin
                r.status = chain_walk(c.cluster, last, cnt);
                if (r.status == ST_OK) r.chain_clusters = 13'(cnt);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_cmd(cmd_row_t c);
        fat_res_t r;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= c.kind;
        i_s_tdata <= {3'b0, c.byte_data, c.byte_address, c.entry_data, c.cluster};
        do @(posedge i_clk); while (!o_s_tready);
        r = table_apply(c);
        if (c.typed) r = c.res;
        if (r.status == ST_OK && (c.kind == K_ALLOCATE || c.kind == K_APPEND)) begin
            chain_heads.push_back(r.result_cluster);
            if (chain_heads.size() > 64) void'(chain_heads.pop_front());
        end
        pending_results.push_back(r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic hold_tx();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        hold_tx();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ENTRIES) cfg_entries = val;
        else cfg_first = val[11:0];
    endtask

    function automatic logic [11:0] pick_cluster();
        int lim;
        lim = in_range_limit();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (chain_heads.size() != 0)
                    return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
                return 12'($urandom_range(0, lim - 1));
            end
            5, 6, 7: return 12'($urandom_range(0, (lim + 1 > 4095) ? 4095 : lim + 1));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int w;
        int lim;
        lim = in_range_limit();
        c = '{K_READ_BYTE, pick_cluster(), 12'd0, 13'd0, 8'($urandom_range(0, 255)),
              1'b0, '{12'd0, 8'd0, 12'd0, 13'd0, ST_OK}};
        c.byte_address = ($urandom_range(0, 9) == 0)
                         ? 13'($urandom_range(TABLE_BYTES, 8191))
                         : 13'($urandom_range(0, lim * 3 / 2));
        case ($urandom_range(0, 3))
            0: c.entry_data = 12'd0;
            1: c.entry_data = 12'($urandom_range(12'hFF8, 12'hFFF));
            2: c.entry_data = 12'($urandom_range(0, lim));
            default: c.entry_data = 12'($urandom_range(0, 4095));
        endcase
        w = $urandom_range(0, 99);
        if (w < 20) c.kind = K_ALLOCATE;
        else if (w < 40) c.kind = K_APPEND;
        else if (w < 48) c.kind = K_FREE_CHAIN;
        else if (w < 56) c.kind = K_CHAIN_LEN;
        else if (w < 64) c.kind = K_FIND_LAST;
        else if (w < 74) c.kind = K_READ_ENTRY;
        else if (w < 82) c.kind = K_WRITE_ENTRY;
        else if (w < 88) c.kind = K_READ_BYTE;
        else if (w < 94) c.kind = K_LOAD_BYTE;
        else c.kind = 4'($urandom_range(9, 15));
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 17);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        fat_res_t e;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL fat12_cluster_table_engine_top");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h/%h",
                                               o_m_tdata, o_m_tuser);
            end else begin
                e = pending_results.pop_front();
                if (o_m_tdata[11:0] !== e.entry_value || o_m_tdata[19:12] !== e.byte_value
                    || o_m_tdata[31:20] !== e.result_cluster
                    || o_m_tdata[44:32] !== e.chain_clusters || o_m_tuser !== e.status) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp ev=%h bv=%h rc=%h cc=%0d st=%0d got ev=%h bv=%h rc=%h cc=%0d st=%0d",
                                 e.entry_value, e.byte_value, e.result_cluster,
                                 e.chain_clusters, e.status, o_m_tdata[11:0],
                                 o_m_tdata[19:12], o_m_tdata[31:20], o_m_tdata[44:32],
                                 o_m_tuser);
                end
            end
        end
    end

    initial begin
        cmd_row_t dir_rows [$];
        cmd_row_t sat_rows [$];
        cmd_row_t c;
        fat_res_t zero_res;
        int phase_entries [8] = '{64, 2, 300, 511, 16, 128, 500, 100};
        int phase_first [8] = '{0, 0, 100, 400, 15, 3, 0, 2};
        int phase_count [8] = '{200, 40, 250, 30, 150, 300, 20, 100};

        zero_res = '{12'd0, 8'd0, 12'd0, 13'd0, ST_OK};
        for (int i = 0; i < TABLE_BYTES; i++) fat_image[i] = 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // clear the low part of the table
        quiet = 1'b1;
        for (int a = 0; a < CLEAR_BYTES; a++) begin
            c = '{K_LOAD_BYTE, 12'd0, 12'd0, 13'(a), 8'd0, 1'b0, zero_res};
            send_cmd(c);
        end
        quiet = 1'b0;
        hold_tx();

        dir_rows = '{
            '{K_READ_BYTE,   12'd0,    12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}},
            '{K_LOAD_BYTE,   12'd0,    12'd0,   13'd6143, 8'h3C,  1, '{0, 0, 0, 0, ST_OK}},
            '{K_READ_BYTE,   12'd0,    12'd0,   13'd6143, 8'd0,   1, '{0, 8'h3C, 0, 0, ST_OK}},
            '{K_READ_BYTE,   12'd0,    12'd0,   13'd6144, 8'd0,   1, '{0, 0, 0, 0, ST_RANGE}},
            '{K_LOAD_BYTE,   12'd0,    12'd0,   13'd8191, 8'hFF,  1, '{0, 0, 0, 0, ST_RANGE}},
            '{K_LOAD_BYTE,   12'd0,    12'd0,   13'd5,    8'hA5,  1, '{0, 0, 0, 0, ST_OK}},
            '{K_READ_BYTE,   12'd0,    12'd0,   13'd5,    8'd0,   1, '{0, 8'hA5, 0, 0, ST_OK}},
            '{K_READ_ENTRY,  12'd511,  12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}},
            '{K_READ_ENTRY,  12'd3072, 12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_RANGE}},
            '{K_WRITE_ENTRY, 12'd4095, 12'hFFF, 13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_RANGE}},
            '{K_WRITE_ENTRY, 12'd3071, 12'hFFF, 13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}},
            '{K_READ_ENTRY,  12'd3071, 12'd0,   13'd0,    8'd0,   1, '{12'hFFF, 0, 0, 0, ST_OK}},
            '{K_ALLOCATE,    12'd0,    12'd0,   13'd0,    8'd0,   1, '{0, 0, 12'd4, 0, ST_OK}},
            '{K_FIND_LAST,   12'd4,    12'd0,   13'd0,    8'd0,   1, '{0, 0, 12'd4, 0, ST_OK}},
            '{K_APPEND,      12'd4,    12'd0,   13'd0,    8'd0,   0, '{0, 0, 0, 0, ST_OK}},
            '{K_CHAIN_LEN,   12'd4,    12'd0,   13'd0,    8'd0,   0, '{0, 0, 0, 0, ST_OK}},
            '{K_FREE_CHAIN,  12'd4,    12'd0,   13'd0,    8'd0,   0, '{0, 0, 0, 0, ST_OK}},
            '{4'd9,          12'd7,    12'd1,   13'd2,    8'd3,   1, '{0, 0, 0, 0, ST_OK}},
            '{4'd15,         12'hFFF,  12'hFFF, 13'h1FFF, 8'hFF,  1, '{0, 0, 0, 0, ST_OK}},
            '{K_WRITE_ENTRY, 12'd10,   12'd10,  13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}},
            '{K_CHAIN_LEN,   12'd10,   12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_LOOP}},
            '{K_WRITE_ENTRY, 12'd11,   12'hFF7, 13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}},
            '{K_FIND_LAST,   12'd11,   12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_RANGE}},
            '{K_FIND_LAST,   12'd4095, 12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_RANGE}},
            '{K_FREE_CHAIN,  12'd3071, 12'd0,   13'd0,    8'd0,   0, '{0, 0, 0, 0, ST_OK}},
            '{K_WRITE_ENTRY, 12'd10,   12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}}
        };
        foreach (dir_rows[i]) send_cmd(dir_rows[i]);

        // entry count above the table size saturates to the full table
        sat_rows = '{
            '{K_WRITE_ENTRY, 12'd4095, 12'hFFF, 13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}},
            '{K_READ_ENTRY,  12'd4095, 12'd0,   13'd0,    8'd0,   1, '{12'hFFF, 0, 0, 0, ST_OK}},
            '{K_CHAIN_LEN,   12'd4095, 12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 13'd1, ST_OK}},
            '{K_FREE_CHAIN,  12'd4095, 12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 13'd1, ST_OK}},
            '{K_READ_ENTRY,  12'd4095, 12'd0,   13'd0,    8'd0,   1, '{0, 0, 0, 0, ST_OK}}
        };
        write_reg(CFG_ENTRIES, 13'd8191);
        foreach (sat_rows[i]) send_cmd(sat_rows[i]);

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_ENTRIES, 13'(phase_entries[p]));
            write_reg(CFG_FIRST, 13'(phase_first[p]));
            chain_heads.delete();
            if (p == 7) quiet = 1'b1;
            for (int n = 0; n < phase_count[p]; n++) send_cmd(random_cmd());
        end

        hold_tx();
        repeat (20) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("PASS fat12_cluster_table_engine_top");
        end else begin
            $display("FAIL fat12_cluster_table_engine_top");
        end
        $finish;
    end
endmodule
